// File: rtl/imoc_pkg.sv
// package: option codes, parser enums, result beat type and option classifier
`timescale 1ns / 1ps

package imoc_pkg;

    localparam int MAX_OPTION_BYTES_DEF = 40;

    localparam logic [7:0] OPT_END       = 8'd0;
    localparam logic [7:0] OPT_NOP       = 8'd1;
    localparam logic [7:0] OPT_SECURITY  = 8'd130;
    localparam logic [7:0] OPT_LSRR      = 8'd131;
    localparam logic [7:0] OPT_EXT_SEC   = 8'h85;
    localparam logic [7:0] OPT_CIPSO     = 8'd134;
    localparam logic [7:0] OPT_SSRR      = 8'd137;
    localparam logic [7:0] OPT_RTR_ALERT = 8'd148;
    localparam logic [7:0] OPT_QUICK     = 8'h80 | 8'd21;

    localparam logic [7:0] OPT_HDR_LEN   = 8'd2;
    localparam logic [7:0] MIN_ROUTE_LEN = 8'd6;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_BODY,
        PH_PASS
    } phase_t;

    typedef enum logic [1:0] {
        CLS_KEEP,
        CLS_ZERO,
        CLS_ROUTE
    } opt_class_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last_byte;
        logic        status;
        logic [31:0] final_dest;
        logic        dest_found;
    } result_t;

    function automatic opt_class_t classify(input logic [7:0] t);
        opt_class_t c;
        c = CLS_ZERO;
        if (t == OPT_SECURITY || t == OPT_EXT_SEC || t == OPT_CIPSO ||
            t == OPT_RTR_ALERT || t == OPT_QUICK)
        begin
            c = CLS_KEEP;
        end
        else if (t == OPT_LSRR || t == OPT_SSRR)
        begin
            c = CLS_ROUTE;
        end
        return c;
    endfunction

endpackage

// File: rtl/imoc_parser.sv
// option parser: per-packet state registers and the per-byte update
`timescale 1ns / 1ps

module imoc_parser #(
    parameter int MAX_OPTION_BYTES = imoc_pkg::MAX_OPTION_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          byte_value,
    input  logic                first_byte,
    input  logic [5:0]          area_len,
    output imoc_pkg::result_t   result
);

    localparam int CW = $clog2(MAX_OPTION_BYTES + 1);
    localparam logic [5:0] MAX_LEN = 6'(MAX_OPTION_BYTES);

    imoc_pkg::phase_t     phase_reg, phase_cur, phase_next;
    imoc_pkg::opt_class_t cls_reg, cls_cur, cls_next;
    logic [CW-1:0]        rem_reg, rem_cur, rem_next;
    logic [CW-1:0]        body_reg, body_cur, body_next;
    logic [31:0]          shift_reg, shift_cur, shift_next;
    logic [31:0]          dest_reg, dest_cur, dest_next;
    logic                 seen_reg, seen_cur, seen_next;
    logic                 mal_reg, mal_cur, mal_next;
    logic [5:0]           alen_clamped;
    logic                 at_end;
    logic [7:0]           ob;
    logic                 last;

    always_comb
    begin
        // clamp the sampled length into 1..max
        alen_clamped = area_len;
        if (alen_clamped == 6'd0)
        begin
            alen_clamped = 6'd1;
        end
        if (alen_clamped > MAX_LEN)
        begin
            alen_clamped = MAX_LEN;
        end

        phase_cur = first_byte ? imoc_pkg::PH_TYPE  : phase_reg;
        cls_cur   = first_byte ? imoc_pkg::CLS_KEEP : cls_reg;
        rem_cur   = first_byte ? CW'(alen_clamped)  : rem_reg;
        body_cur  = first_byte ? '0 : body_reg;
        shift_cur = first_byte ? '0 : shift_reg;
        dest_cur  = first_byte ? '0 : dest_reg;
        seen_cur  = first_byte ? 1'b0 : seen_reg;
        mal_cur   = first_byte ? 1'b0 : mal_reg;

        phase_next = phase_cur;
        cls_next   = cls_cur;
        rem_next   = rem_cur;
        body_next  = body_cur;
        shift_next = shift_cur;
        dest_next  = dest_cur;
        seen_next  = seen_cur;
        mal_next   = mal_cur;
        ob         = byte_value;
        last       = 1'b0;
        at_end     = (rem_cur == CW'(1));

        if (rem_cur != '0)
        begin
            case (phase_cur)
                imoc_pkg::PH_TYPE:
                begin
                    if (byte_value == imoc_pkg::OPT_END)
                    begin
                        phase_next = imoc_pkg::PH_PASS;
                    end
                    else if (byte_value != imoc_pkg::OPT_NOP)
                    begin
                        cls_next = imoc_pkg::classify(byte_value);
                        if (cls_next != imoc_pkg::CLS_KEEP)
                        begin
                            ob = 8'd0;
                        end
                        if (at_end)
                        begin
                            mal_next   = 1'b1;
                            phase_next = imoc_pkg::PH_PASS;
                        end
                        else
                        begin
                            phase_next = imoc_pkg::PH_LEN;
                        end
                    end
                end
                imoc_pkg::PH_LEN:
                begin
                    if (byte_value < imoc_pkg::OPT_HDR_LEN ||
                        {1'b0, byte_value} > (9'(rem_cur) + 9'd1) ||
                        (cls_cur == imoc_pkg::CLS_ROUTE &&
                         byte_value < imoc_pkg::MIN_ROUTE_LEN))
                    begin
                        mal_next   = 1'b1;
                        phase_next = imoc_pkg::PH_PASS;
                    end
                    else
                    begin
                        if (cls_cur != imoc_pkg::CLS_KEEP)
                        begin
                            ob = 8'd0;
                        end
                        body_next  = CW'(byte_value - imoc_pkg::OPT_HDR_LEN);
                        shift_next = '0;
                        phase_next = (body_next == '0) ? imoc_pkg::PH_TYPE
                                                       : imoc_pkg::PH_BODY;
                    end
                end
                imoc_pkg::PH_BODY:
                begin
                    if (cls_cur != imoc_pkg::CLS_KEEP)
                    begin
                        ob = 8'd0;
                    end
                    if (cls_cur == imoc_pkg::CLS_ROUTE)
                    begin
                        shift_next = {shift_cur[23:0], byte_value};
                    end
                    body_next = body_cur - CW'(1);
                    if (body_next == '0)
                    begin
                        if (cls_cur == imoc_pkg::CLS_ROUTE)
                        begin
                            dest_next = shift_next;
                            seen_next = 1'b1;
                        end
                        phase_next = imoc_pkg::PH_TYPE;
                    end
                end
                default:
                begin
                end
            endcase
            rem_next = rem_cur - CW'(1);
            if (rem_next == '0)
            begin
                last       = 1'b1;
                phase_next = imoc_pkg::PH_TYPE;
            end
        end

        result.out_byte   = ob;
        result.last_byte  = last;
        result.status     = mal_next;
        result.final_dest = dest_next;
        result.dest_found = seen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= imoc_pkg::PH_TYPE;
            cls_reg   <= imoc_pkg::CLS_KEEP;
            rem_reg   <= '0;
            body_reg  <= '0;
            shift_reg <= '0;
            dest_reg  <= '0;
            seen_reg  <= 1'b0;
            mal_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            cls_reg   <= cls_next;
            rem_reg   <= rem_next;
            body_reg  <= body_next;
            shift_reg <= shift_next;
            dest_reg  <= dest_next;
            seen_reg  <= seen_next;
            mal_reg   <= mal_next;
        end
    end

endmodule

// File: rtl/imoc_out_buf.sv
// two-entry result buffer: output register plus skid entry
`timescale 1ns / 1ps

module imoc_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  imoc_pkg::result_t   push_data,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output imoc_pkg::result_t   out_data
);

    imoc_pkg::result_t head_reg, head_next;
    imoc_pkg::result_t skid_reg, skid_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign out_data  = head_reg;
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        head_next = head_reg;
        skid_next = skid_reg;
        cnt_next  = cnt_reg;
        case (cnt_reg)
            2'd0:
            begin
                if (push)
                begin
                    head_next = push_data;
                    cnt_next  = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    head_next = push_data;
                end
                else if (push)
                begin
                    skid_next = push_data;
                    cnt_next  = 2'd2;
                end
                else if (pop)
                begin
                    cnt_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    head_next = skid_reg;
                    cnt_next  = 2'd1;
                end
            end
            default:
            begin
                cnt_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

// File: rtl/ipv4_mutable_option_clearer.sv
// top level: ipv4 options-area mutable option clearer for ah icv input
`timescale 1ns / 1ps

// usage
// - input channel: in_valid / in_stall carry one options-area byte per beat,
//   with first_byte marking the start of a packet's area (area_len sampled then)
// - output channel: out_valid / out_stall carry one result beat per input beat,
//   in order: the byte (zeroed inside mutable options), last_byte, sticky
//   status, and the final destination captured from the latest source route
// - a result beat is registered into the result buffer as its input is taken
// - throughput: one beat per cycle, sustained while out_stall stays low
// - the whole per-byte parser update is combinational logic between
//   the parser state registers and the result buffer
// - stall: the result buffer holds two beats (output register plus skid), so
//   in_stall is raised only once both are occupied and comes straight from a
//   register; nothing is dropped while the receiver stalls
// - reset: rst_n clears the parser to expect an option type with no area
//   open and empties the result buffer; bytes before the first first_byte
//   pass unchanged

module ipv4_mutable_option_clearer #(
    parameter int MAX_OPTION_BYTES = imoc_pkg::MAX_OPTION_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    // input beats
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        first_byte,
    input  logic [5:0]  area_len,

    // result beats
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_byte,
    output logic        status,
    output logic [31:0] final_dest,
    output logic        dest_found
);

    imoc_pkg::result_t parse_res;
    imoc_pkg::result_t head_res;
    logic              buf_full;
    logic              take;

    // a beat is taken whenever the buffer has a free entry
    assign in_stall = buf_full;
    assign take     = in_valid && !buf_full;

    imoc_parser #(
        .MAX_OPTION_BYTES (MAX_OPTION_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .byte_value (byte_value),
        .first_byte (first_byte),
        .area_len   (area_len),
        .result     (parse_res)
    );

    imoc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (parse_res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (head_res)
    );

    // unpack the head beat onto the result ports
    assign out_byte   = head_res.out_byte;
    assign last_byte  = head_res.last_byte;
    assign status     = head_res.status;
    assign final_dest = head_res.final_dest;
    assign dest_found = head_res.dest_found;

endmodule
